[design/sfrr_pkg.sv]
// ----------------------------------------------------------------------------
// sfrr_pkg - shared definitions for the SLIP frame receive router
// Framing codes, store geometry, header positions, verdict codes and the
// result record used between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package sfrr_pkg;

  // SLIP framing codes
  localparam logic [7:0] FRAME_END     = 8'hC0;
  localparam logic [7:0] FRAME_ESC     = 8'hDB;
  localparam logic [7:0] FRAME_ESC_END = 8'hDC;

  // Frame store geometry
  localparam int MAX_FRAME   = 250;
  localparam int STORE_DEPTH = (MAX_FRAME > 256) ? MAX_FRAME : 256;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int FILL_W      = $clog2(MAX_FRAME + 1);

  // Header byte positions
  localparam int POS_PROTO  = 6;
  localparam int POS_SRC_HI = 8;
  localparam int POS_SRC_LO = 9;
  localparam int POS_DST_HI = 10;
  localparam int POS_DST_LO = 11;
  localparam int POS_CMD    = 12;
  localparam int POS_PLEN   = 13;
  localparam int MIN_HEADER = 12;

  // Verdict codes
  localparam logic [1:0] VERDICT_SHORT   = 2'd0;
  localparam logic [1:0] VERDICT_LOCAL   = 2'd1;
  localparam logic [1:0] VERDICT_FORWARD = 2'd2;
  localparam logic [1:0] VERDICT_IGNORED = 2'd3;

  // Stream widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 80;

  // Result record (everything but the readback byte and the readback flag)
  typedef struct packed {
    logic [1:0]  verdict;
    logic [7:0]  frame_length;
    logic [7:0]  protocol_byte;
    logic [15:0] source_address;
    logic [15:0] dest_address;
    logic [7:0]  command_byte;
    logic [7:0]  payload_length;
  } result_t;

endpackage

`default_nettype wire

[design/slip_frame_receive_router_unit.sv]
// ----------------------------------------------------------------------------
// slip_frame_receive_router_unit - SLIP decoder with frame verdict and readback
// Removes SLIP framing from a byte stream, keeps decoded bytes in a frame
// store and issues one verdict per closed non-empty frame.
// ----------------------------------------------------------------------------
// Pipeline: a result passes through the decode/read stage, then the output
//   register, before it is offered on m_tvalid.
// Throughput: one request per cycle unless m_tready stalls the output; the single
//   write port and single registered read port of the frame store each serve one request.
// Reset (rst, synchronous): clears fill count, escape flag, own_address,
//   pipeline valids and the per-entry valid bits of the frame store at once;
//   no clearing pass, requests are taken from the first cycle after reset.
`default_nettype none

module slip_frame_receive_router_unit (
  input  wire                           clk,
  input  wire                           rst,
  // configuration
  input  wire                           cfg_we,
  input  wire  [15:0]                   cfg_wdata,  // own_address
  // request stream
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire  [sfrr_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] serial_byte, [15:8] read_index
  input  wire  [0:0]                    s_tuser,    // [0] kind (1 = read frame store)
  // result stream
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [sfrr_pkg::M_TDATA_W-1:0] m_tdata,   // [1:0] verdict, [9:2] frame_length,
                                                    // [17:10] protocol_byte,
                                                    // [33:18] source_address,
                                                    // [49:34] dest_address,
                                                    // [57:50] command_byte,
                                                    // [65:58] payload_length,
                                                    // [73:66] read_byte, [79:74] zero
  output logic [0:0]                    m_tuser     // [0] is_readback
);
  import sfrr_pkg::*;

  // --------------------------------------------------------------------------
  // Control and configuration state
  // --------------------------------------------------------------------------
  logic [15:0]       own_address;
  logic [FILL_W-1:0] fill_count;
  logic              escape_pending;

  // Header shadow registers, loaded as the header bytes are stored. Only read
  // when the frame is long enough for them to be from the current frame.
  logic [7:0]  hdr_proto;
  logic [15:0] hdr_src;
  logic [15:0] hdr_dst;
  logic [7:0]  hdr_cmd;
  logic [7:0]  hdr_plen;

  // Frame store: one write port, one registered read port, valid bit per entry
  logic [7:0]             store_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] store_vld;
  logic [7:0]             store_q;

  // Stage 1: request decoded, readback data on its way out of the store
  logic    s1_valid;
  logic    s1_readback;
  logic    s1_rd_vld;
  result_t s1_res;
  logic    s1_adv;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic                req_acc;
  logic                byte_acc;
  logic                read_acc;
  logic [7:0]          rx_byte;
  logic                is_end;
  logic                is_esc;
  logic [7:0]          dec_byte;
  logic                store_we;
  logic                frame_close;
  logic [STORE_AW-1:0] wr_addr;
  logic [STORE_AW-1:0] rd_addr;
  result_t             verdict_res;

  // Stage 1 moves on whenever the output register is free or being emptied;
  // a new request may enter in the same cycle.
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  assign req_acc  = s_tvalid && s_tready;
  assign byte_acc = req_acc && !s_tuser[0];
  assign read_acc = req_acc && s_tuser[0];

  assign rx_byte = s_tdata[7:0];
  assign is_end  = (rx_byte == FRAME_END);
  assign is_esc  = (rx_byte == FRAME_ESC);

  // After ESC: ESC_END decodes to END, anything else to ESC
  assign dec_byte = escape_pending ? ((rx_byte == FRAME_ESC_END) ? FRAME_END : FRAME_ESC)
                                   : rx_byte;

  // Bytes past MAX_FRAME are decoded but dropped
  assign store_we    = byte_acc && !is_end && !is_esc && (fill_count < FILL_W'(MAX_FRAME));
  assign frame_close = byte_acc && is_end && (fill_count != '0);

  assign wr_addr = STORE_AW'(fill_count);
  assign rd_addr = STORE_AW'(s_tdata[15:8]);

  // Verdict from the current fill count and header shadows
  always_comb begin
    verdict_res              = '0;
    verdict_res.frame_length = 8'(fill_count);
    if (fill_count >= FILL_W'(MIN_HEADER)) begin
      verdict_res.protocol_byte  = hdr_proto;
      verdict_res.source_address = hdr_src;
      verdict_res.dest_address   = hdr_dst;
      if (hdr_dst == own_address && hdr_proto == 8'd0) begin
        verdict_res.verdict = VERDICT_LOCAL;
      end else if (hdr_proto != 8'd0) begin
        verdict_res.verdict = VERDICT_FORWARD;
      end else begin
        verdict_res.verdict = VERDICT_IGNORED;
      end
      // 12- and 13-byte frames: positions beyond the end read as zero
      if (fill_count > FILL_W'(POS_CMD)) begin
        verdict_res.command_byte = hdr_cmd;
      end
      if (fill_count > FILL_W'(POS_PLEN)) begin
        verdict_res.payload_length = hdr_plen;
      end
    end else begin
      verdict_res.verdict = VERDICT_SHORT;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_we) begin
      own_address <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Decoder state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      escape_pending <= 1'b0;
    end else if (byte_acc) begin
      // END leaves a pending escape standing; ESC after ESC keeps it set
      if (is_end) begin
        fill_count <= '0;
      end else if (is_esc) begin
        escape_pending <= 1'b1;
      end else begin
        escape_pending <= 1'b0;
        if (store_we) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  // Header shadows follow the store writes at the fixed header positions
  always_ff @(posedge clk) begin
    if (store_we) begin
      case (fill_count)
        FILL_W'(POS_PROTO):  hdr_proto      <= dec_byte;
        FILL_W'(POS_SRC_HI): hdr_src[15:8]  <= dec_byte;
        FILL_W'(POS_SRC_LO): hdr_src[7:0]   <= dec_byte;
        FILL_W'(POS_DST_HI): hdr_dst[15:8]  <= dec_byte;
        FILL_W'(POS_DST_LO): hdr_dst[7:0]   <= dec_byte;
        FILL_W'(POS_CMD):    hdr_cmd        <= dec_byte;
        FILL_W'(POS_PLEN):   hdr_plen       <= dec_byte;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame store. A read is always accepted in a later cycle than any earlier
  // write, so the registered read sees it without forwarding. Entries never
  // written since reset read as zero through the valid bits.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[wr_addr] <= dec_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (read_acc) begin
      store_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_vld <= '0;
    end else if (store_we) begin
      store_vld[wr_addr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1. store_q only changes on an accepted read, which cannot happen
  // while stage 1 is held, so it stays aligned with s1_rd_vld.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= read_acc || frame_close;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_readback <= s_tuser[0];
      s1_rd_vld   <= s_tuser[0] && store_vld[rd_addr];
      s1_res      <= s_tuser[0] ? '0 : verdict_res;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tuser <= s1_readback;
      m_tdata <= {6'd0,
                  (s1_rd_vld ? store_q : 8'd0),
                  s1_res.payload_length,
                  s1_res.command_byte,
                  s1_res.dest_address,
                  s1_res.source_address,
                  s1_res.protocol_byte,
                  s1_res.frame_length,
                  s1_res.verdict};
    end
  end

endmodule

`default_nettype wire

[design/sfrr_checker.sv]
// ----------------------------------------------------------------------------
// sfrr_checker - port-level checks for the SLIP frame receive router
// Watches the result stream for field rules of verdicts and readbacks.
// ----------------------------------------------------------------------------
`default_nettype none

module sfrr_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            m_tvalid,
  input wire                            m_tready,
  input wire [sfrr_pkg::M_TDATA_W-1:0]  m_tdata,
  input wire [0:0]                      m_tuser
);
  import sfrr_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // readback carries only the byte
  a_rb_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[65:0] == '0)
    else $error("readback with verdict fields set");

  // verdict: non-empty frame, no readback byte
  a_verdict_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[73:66] == 8'd0 && m_tdata[9:2] != 8'd0)
    else $error("verdict with readback byte or empty frame");

  // short verdict carries no header
  a_short: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && m_tdata[1:0] == VERDICT_SHORT |-> m_tdata[65:10] == '0)
    else $error("short verdict with header fields");

endmodule

bind slip_frame_receive_router_unit sfrr_checker u_sfrr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
